// File: rtl/rs_pkg.sv
package rs_pkg;

   localparam int COORD_W = 16;
   localparam int STRIPS  = 4;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int SLOT_W  = $clog2(STRIPS);

   // axis classes of the clipped subtrahend against the minuend
   localparam logic [1:0] CLS_LOW  = 2'd1;
   localparam logic [1:0] CLS_IN   = 2'd2;
   localparam logic [1:0] CLS_HIGH = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   // one classified transaction: candidate strips in emit order plus a mask
   typedef struct packed {
      rect_type [STRIPS-1:0] strip;
      logic [STRIPS-1:0]     mask;
      logic                  none_left;
   } entry_type;

   typedef struct packed {
      logic              empty;
      logic [QPTR_W:0]   count;
   } qstat_type;

endpackage

// File: rtl/rs_front.sv
module rs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rs_pkg::rect_type     rect_a,
   input  rs_pkg::rect_type     rect_b,
   output logic                 push,
   output rs_pkg::entry_type    entry
);

   logic             s1_valid_ff, s1_valid_in;
   rs_pkg::rect_type a_ff, a_in, b_ff, b_in;

   // sort stage: put each corner pair in ascending order
   always_comb begin
      s1_valid_in = accept;
      a_in.left   = (rect_a.left > rect_a.right)  ? rect_a.right  : rect_a.left;
      a_in.right  = (rect_a.left > rect_a.right)  ? rect_a.left   : rect_a.right;
      a_in.top    = (rect_a.top  > rect_a.bottom) ? rect_a.bottom : rect_a.top;
      a_in.bottom = (rect_a.top  > rect_a.bottom) ? rect_a.top    : rect_a.bottom;
      b_in.left   = (rect_b.left > rect_b.right)  ? rect_b.right  : rect_b.left;
      b_in.right  = (rect_b.left > rect_b.right)  ? rect_b.left   : rect_b.right;
      b_in.top    = (rect_b.top  > rect_b.bottom) ? rect_b.bottom : rect_b.top;
      b_in.bottom = (rect_b.top  > rect_b.bottom) ? rect_b.top    : rect_b.bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   function automatic logic [1:0] axis_class(rs_pkg::coord_type a0, rs_pkg::coord_type a1,
                                             rs_pkg::coord_type b0, rs_pkg::coord_type b1);
      if (b0 == a0)      return rs_pkg::CLS_LOW;
      else if (b1 == a1) return rs_pkg::CLS_HIGH;
      else               return rs_pkg::CLS_IN;
   endfunction

   function automatic rs_pkg::rect_type mk(rs_pkg::coord_type l, rs_pkg::coord_type t,
                                           rs_pkg::coord_type r, rs_pkg::coord_type b);
      rs_pkg::rect_type v;
      v.left = l; v.top = t; v.right = r; v.bottom = b;
      return v;
   endfunction

   // classify stage
   logic              disjoint;
   rs_pkg::coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   rs_pkg::coord_type bx0m1, bx1p1, by0m1, by1p1;
   logic [1:0]        cls_x, cls_y;
   logic              x_rest, y_rest;
   rs_pkg::entry_type build;

   always_comb begin
      ax0 = a_ff.left;  ax1 = a_ff.right;
      ay0 = a_ff.top;   ay1 = a_ff.bottom;
      disjoint = (b_ff.right < ax0) || (b_ff.left > ax1) ||
                 (b_ff.bottom < ay0) || (b_ff.top > ay1);
      // clip B to A
      bx0 = (b_ff.left   < ax0) ? ax0 : b_ff.left;
      bx1 = (b_ff.right  > ax1) ? ax1 : b_ff.right;
      by0 = (b_ff.top    < ay0) ? ay0 : b_ff.top;
      by1 = (b_ff.bottom > ay1) ? ay1 : b_ff.bottom;
      bx0m1 = bx0 - rs_pkg::coord_type'(1);
      bx1p1 = bx1 + rs_pkg::coord_type'(1);
      by0m1 = by0 - rs_pkg::coord_type'(1);
      by1p1 = by1 + rs_pkg::coord_type'(1);
      cls_x = axis_class(ax0, ax1, bx0, bx1);
      cls_y = axis_class(ay0, ay1, by0, by1);
      x_rest = (ax1 != bx1);
      y_rest = (ay1 != by1);

      build.strip     = '0;
      build.mask      = '0;
      build.none_left = 1'b0;
      case ({cls_x, cls_y})
         {rs_pkg::CLS_IN, rs_pkg::CLS_IN}: begin
            build.strip[0] = mk(ax0, ay0, bx0m1, ay1);
            build.strip[1] = mk(bx0, ay0, bx1, by0m1);
            build.strip[2] = mk(bx0, by1p1, bx1, ay1);
            build.strip[3] = mk(bx1p1, ay0, ax1, ay1);
            build.mask     = 4'b1111;
         end
         {rs_pkg::CLS_LOW, rs_pkg::CLS_IN}: begin
            build.strip[0] = mk(ax0, ay0, bx1, by0m1);
            build.strip[1] = mk(ax0, by1p1, bx1, ay1);
            build.strip[2] = mk(bx1p1, ay0, ax1, ay1);
            build.mask     = {1'b0, x_rest, 2'b11};
         end
         {rs_pkg::CLS_HIGH, rs_pkg::CLS_IN}: begin
            build.strip[0] = mk(ax0, ay0, ax1, by0m1);
            build.strip[1] = mk(ax0, by0, bx0m1, by1);
            build.strip[2] = mk(ax0, by1p1, ax1, ay1);
            build.mask     = 4'b0111;
         end
         {rs_pkg::CLS_IN, rs_pkg::CLS_LOW}: begin
            build.strip[0] = mk(ax0, ay0, bx0m1, by1);
            build.strip[1] = mk(bx1p1, ay0, ax1, by1);
            build.strip[2] = mk(ax0, by1p1, ax1, ay1);
            build.mask     = {1'b0, y_rest, 2'b11};
         end
         {rs_pkg::CLS_IN, rs_pkg::CLS_HIGH}: begin
            build.strip[0] = mk(ax0, ay0, ax1, by0m1);
            build.strip[1] = mk(ax0, by0, bx0m1, ay1);
            build.strip[2] = mk(bx1p1, by0, ax1, ay1);
            build.mask     = 4'b0111;
         end
         {rs_pkg::CLS_HIGH, rs_pkg::CLS_LOW}: begin
            build.strip[0] = mk(ax0, ay0, bx0m1, ay1);
            build.strip[1] = mk(bx0, by1p1, ax1, ay1);
            build.mask     = {2'b00, y_rest, 1'b1};
         end
         {rs_pkg::CLS_HIGH, rs_pkg::CLS_HIGH}: begin
            build.strip[0] = mk(ax0, ay0, bx0m1, ay1);
            build.strip[1] = mk(bx0, ay0, ax1, by0m1);
            build.mask     = 4'b0011;
         end
         {rs_pkg::CLS_LOW, rs_pkg::CLS_LOW}: begin
            build.strip[0] = mk(bx1p1, ay0, ax1, ay1);
            build.strip[1] = mk(ax0, by1p1, bx1, ay1);
            build.mask     = {2'b00, y_rest, x_rest};
         end
         default: begin
            // low x, high y
            build.strip[0] = mk(bx1p1, ay0, ax1, ay1);
            build.strip[1] = mk(ax0, ay0, bx1, by0m1);
            build.mask     = {2'b00, 1'b1, x_rest};
         end
      endcase

      if (disjoint) begin
         build.strip     = '0;
         build.strip[0]  = a_ff;
         build.mask      = 4'b0001;
         build.none_left = 1'b0;
      end else if (build.mask == '0) begin
         // B swallows A: one marker transaction with zero corners
         build.strip     = '0;
         build.mask      = 4'b0001;
         build.none_left = 1'b1;
      end
   end

   assign push  = s1_valid_ff;
   assign entry = build;

endmodule

// File: rtl/rs_queue.sv
module rs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rs_pkg::entry_type  push_entry,
   input  logic               pop,
   output rs_pkg::entry_type  head,
   output rs_pkg::qstat_type  stat
);

   rs_pkg::entry_type              mem [rs_pkg::QDEPTH];
   logic [rs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rs_pkg::QPTR_W:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + (rs_pkg::QPTR_W)'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + (rs_pkg::QPTR_W)'(1) : rd_ptr_ff;
      count_in  = count_ff + (rs_pkg::QPTR_W+1)'(push) - (rs_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = mem[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;

endmodule

// File: rtl/rs_back.sv
module rs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               have_head,
   input  rs_pkg::entry_type  head,
   output logic               pop,
   output logic               out_strobe,
   output rs_pkg::rect_type   out_piece,
   output logic               out_none_left,
   output logic               out_last
);

   logic [rs_pkg::STRIPS-1:0] rem_ff, rem_in, cur, nxt;
   logic                      started_ff, started_in;
   logic [rs_pkg::SLOT_W-1:0] slot;
   logic                      strobe_ff, strobe_in;
   rs_pkg::rect_type          piece_ff, piece_in;
   logic                      none_ff, none_in, last_ff, last_in;

   always_comb begin
      cur  = started_ff ? rem_ff : head.mask;
      slot = '0;
      for (int k = rs_pkg::STRIPS - 1; k >= 0; k--) begin
         if (cur[k]) slot = rs_pkg::SLOT_W'(k);
      end
      nxt = cur;
      nxt[slot] = 1'b0;

      pop        = have_head && (nxt == '0);
      strobe_in  = have_head;
      piece_in   = head.strip[slot];
      none_in    = head.none_left;
      last_in    = (nxt == '0);
      started_in = have_head ? (nxt != '0) : started_ff;
      rem_in     = have_head ? nxt : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         started_ff <= started_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (have_head) begin
         piece_ff <= piece_in;
         none_ff  <= none_in;
         last_ff  <= last_in;
      end
   end

   assign out_strobe    = strobe_ff;
   assign out_piece     = piece_ff;
   assign out_none_left = none_ff;
   assign out_last      = last_ff;

endmodule

// File: rtl/rectangle_subtract_unit.sv
// A taken start is registered in the sort stage, classified into the queue, and its first
//   strip is registered at the output; it waits while earlier transactions are still queued.
// Throughput: one strip per cycle on the result side, 1 to 4 strips per transaction;
//   start is taken every cycle while the 4-entry queue has room.
// Reset (synchronous, active high) empties the pipeline and queue and drops the strobe.
// Results cannot be held off; rsp_strobe marks each one for a single cycle.
module rectangle_subtract_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [15:0]       req_a_left,
   input  logic signed [15:0]       req_a_top,
   input  logic signed [15:0]       req_a_right,
   input  logic signed [15:0]       req_a_bottom,
   input  logic signed [15:0]       req_b_left,
   input  logic signed [15:0]       req_b_top,
   input  logic signed [15:0]       req_b_right,
   input  logic signed [15:0]       req_b_bottom,
   output logic                     rsp_strobe,
   output logic signed [15:0]       rsp_piece_left,
   output logic signed [15:0]       rsp_piece_top,
   output logic signed [15:0]       rsp_piece_right,
   output logic signed [15:0]       rsp_piece_bottom,
   output logic                     rsp_none_left,
   output logic                     rsp_last
);

   rs_pkg::rect_type   rect_a, rect_b, piece;
   rs_pkg::entry_type  front_entry, head;
   rs_pkg::qstat_type  qstat;
   logic               accept, push, pop, front_busy;

   assign rect_a = '{left: req_a_left, top: req_a_top, right: req_a_right,
                     bottom: req_a_bottom};
   assign rect_b = '{left: req_b_left, top: req_b_top, right: req_b_right,
                     bottom: req_b_bottom};

   // The sort stage pushes into the queue unconditionally in the cycle after it
   // loads, so a transaction is only taken if the queue is sure to have room
   // for it and for whatever already sits in the sort stage.
   assign front_busy = ({1'b0, qstat.count} + {{(rs_pkg::QPTR_W+1){1'b0}}, push})
                       >= (rs_pkg::QPTR_W+2)'(rs_pkg::QDEPTH);
   assign busy   = front_busy;
   assign accept = start && !front_busy;

   // front: sort corners, then clip/classify and build the strip list
   rs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .rect_a (rect_a),
      .rect_b (rect_b),
      .push   (push),
      .entry  (front_entry)
   );

   // decouples classification from the one-strip-per-cycle emitter
   rs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   // back: walks the strip mask of the head entry, one strip per cycle,
   // and retires the entry with the strip that carries last
   rs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .have_head     (!qstat.empty),
      .head          (head),
      .pop           (pop),
      .out_strobe    (rsp_strobe),
      .out_piece     (piece),
      .out_none_left (rsp_none_left),
      .out_last      (rsp_last)
   );

   assign rsp_piece_left   = piece.left;
   assign rsp_piece_top    = piece.top;
   assign rsp_piece_right  = piece.right;
   assign rsp_piece_bottom = piece.bottom;

endmodule

// File: rtl/rs_checker.sv
module rs_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                rsp_strobe,
   input  logic signed [15:0]  rsp_piece_left,
   input  logic signed [15:0]  rsp_piece_top,
   input  logic signed [15:0]  rsp_piece_right,
   input  logic signed [15:0]  rsp_piece_bottom,
   input  logic                rsp_none_left,
   input  logic                rsp_last
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // a fully covered A gives one zero marker that also closes the transaction
   a_none_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_none_left |-> rsp_last && rsp_piece_left == 16'sd0 &&
         rsp_piece_top == 16'sd0 && rsp_piece_right == 16'sd0 &&
         rsp_piece_bottom == 16'sd0)
      else $error("none_left result malformed");

   // strips of one transaction leave in consecutive cycles
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && !rsp_none_left)
      else $error("gap inside a strip burst");

   // every strip is well formed
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_none_left |->
         rsp_piece_left <= rsp_piece_right && rsp_piece_top <= rsp_piece_bottom)
      else $error("strip corners out of order");

   // with nothing taken, the block drains and cannot stay busy
   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      !start && !rsp_strobe |=> !busy)
      else $error("busy with nothing in flight");

endmodule

bind rectangle_subtract_unit rs_checker u_rs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_piece_left   (rsp_piece_left),
   .rsp_piece_top    (rsp_piece_top),
   .rsp_piece_right  (rsp_piece_right),
   .rsp_piece_bottom (rsp_piece_bottom),
   .rsp_none_left    (rsp_none_left),
   .rsp_last         (rsp_last)
);
